FILE: sv/bpsrs_pkg.sv
`timescale 1ns / 1ps

package bpsrs_pkg;

   localparam int RING_DEPTH = 10;
   localparam int NUM_MODES  = 4;

   localparam int CUR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int MODE_W = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;

   localparam logic [7:0] DEV_ADDR_RESET = 8'hE3;
   localparam logic [7:0] OP_READ_CODE   = 8'h21;
   localparam logic [7:0] OP_WRITE_CODE  = 8'h31;
   localparam logic [7:0] REG_MODE_CODE  = 8'hB3;
   localparam logic [7:0] REG_RING_CODE  = 8'hC3;

   localparam int RING_INIT_LEN = 10;
   localparam logic [7:0] RING_INIT [RING_INIT_LEN] = '{
      8'd238, 8'd54, 8'd191, 8'd174, 8'd103, 8'd228, 8'd184, 8'd57, 8'd206, 8'd13
   };

   function automatic logic [7:0] ring_init_value(input int idx);
      logic [7:0] v;
      v = 8'd0;
      if (idx < RING_INIT_LEN) begin
         v = RING_INIT[idx];
      end
      return v;
   endfunction

   typedef struct packed {
      logic load;
      logic fail;
      logic ring_wr;
      logic ring_rd;
      logic mode_wr;
      logic mode_rd;
   } ctl_cmd_type;

   typedef struct packed {
      logic addr_hit;
      logic op_read_hit;
      logic op_write_hit;
      logic reg_mode_hit;
      logic reg_ring_hit;
      logic mode_ok;
   } dp_stat_type;

endpackage

FILE: sv/bpsrs_ctrl.sv
`timescale 1ns / 1ps

module bpsrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  bpsrs_pkg::dp_stat_type stat,
   output bpsrs_pkg::ctl_cmd_type cmd
);
   import bpsrs_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_OPEN,
      PH_SELECT,
      PH_DATA,
      PH_END
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      is_write_ff, is_write_in;
   logic      sel_ring_ff, sel_ring_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      phase_in     = phase_ff;
      is_write_in  = is_write_ff;
      sel_ring_in  = sel_ring_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      if (accept) begin
         rsp_valid_in = 1'b1;
         cmd.load     = 1'b1;
         if (!req_opcode) begin
            case (phase_ff)
               PH_IDLE: begin
                  if (stat.addr_hit) phase_in = PH_OPEN;
                  else cmd.fail = 1'b1;
               end
               PH_OPEN: begin
                  if (stat.addr_hit) begin
                     phase_in = PH_IDLE;
                  end else if (stat.op_read_hit || stat.op_write_hit) begin
                     is_write_in = stat.op_write_hit;
                     phase_in    = PH_SELECT;
                  end else begin
                     cmd.fail = 1'b1;
                  end
               end
               PH_SELECT: begin
                  if (stat.addr_hit) begin
                     phase_in = PH_IDLE;
                  end else if (stat.reg_mode_hit || stat.reg_ring_hit) begin
                     sel_ring_in = stat.reg_ring_hit;
                     phase_in    = PH_DATA;
                  end else begin
                     cmd.fail = 1'b1;
                  end
               end
               PH_DATA: begin
                  phase_in = PH_END;
                  if (!is_write_ff) cmd.fail = 1'b1;
                  else if (sel_ring_ff) cmd.ring_wr = 1'b1;
                  else if (stat.mode_ok) cmd.mode_wr = 1'b1;
                  else cmd.fail = 1'b1;
               end
               PH_END: begin
                  if (stat.addr_hit) phase_in = PH_IDLE;
                  else cmd.fail = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
                  cmd.fail = 1'b1;
               end
            endcase
         end else begin
            if (phase_ff == PH_DATA) begin
               phase_in = PH_END;
               if (is_write_ff) cmd.fail = 1'b1;
               else if (sel_ring_ff) cmd.ring_rd = 1'b1;
               else cmd.mode_rd = 1'b1;
            end else begin
               phase_in = PH_IDLE;
               cmd.fail = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         is_write_ff  <= 1'b0;
         sel_ring_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         is_write_ff  <= is_write_in;
         sel_ring_ff  <= sel_ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/bpsrs_datapath.sv
`timescale 1ns / 1ps

module bpsrs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data,
   input  logic [7:0]             req_data_byte,
   input  bpsrs_pkg::ctl_cmd_type cmd,
   output bpsrs_pkg::dp_stat_type stat,
   output logic                   rsp_status,
   output logic [7:0]             rsp_read_data
);
   import bpsrs_pkg::*;

   logic [7:0]        dev_addr_ff, dev_addr_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [7:0]        ring_ff [RING_DEPTH];
   logic [7:0]        ring_in [RING_DEPTH];
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic              status_ff, status_in;
   logic [7:0]        rdata_ff, rdata_in;
   logic [7:0]        mode_ext;

   assign stat.addr_hit     = (req_data_byte == dev_addr_ff);
   assign stat.op_read_hit  = (req_data_byte == OP_READ_CODE);
   assign stat.op_write_hit = (req_data_byte == OP_WRITE_CODE);
   assign stat.reg_mode_hit = (req_data_byte == REG_MODE_CODE);
   assign stat.reg_ring_hit = (req_data_byte == REG_RING_CODE);
   assign stat.mode_ok      = ({1'b0, req_data_byte} < 9'(NUM_MODES));

   always_comb begin
      mode_ext = '0;
      mode_ext[MODE_W-1:0] = mode_ff;
   end

   always_comb begin
      dev_addr_in = csr_write_enable ? csr_write_data : dev_addr_ff;
      mode_in     = cmd.mode_wr ? req_data_byte[MODE_W-1:0] : mode_ff;
      ring_in     = ring_ff;
      cursor_in   = cursor_ff;
      if (cmd.ring_wr) begin
         ring_in[cursor_ff] = req_data_byte;
      end
      if (cmd.ring_wr || cmd.ring_rd) begin
         if (cursor_ff == CUR_W'(RING_DEPTH - 1)) cursor_in = '0;
         else cursor_in = cursor_ff + CUR_W'(1);
      end
      status_in = status_ff;
      rdata_in  = rdata_ff;
      if (cmd.load) begin
         status_in = cmd.fail;
         if (cmd.ring_rd) rdata_in = ring_ff[cursor_ff];
         else if (cmd.mode_rd) rdata_in = mode_ext;
         else rdata_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEV_ADDR_RESET;
         mode_ff     <= '0;
         cursor_ff   <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= ring_init_value(i);
         end
      end else begin
         dev_addr_ff <= dev_addr_in;
         mode_ff     <= mode_in;
         cursor_ff   <= cursor_in;
         ring_ff     <= ring_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rdata_ff  <= rdata_in;
   end

   assign rsp_status    = status_ff;
   assign rsp_read_data = rdata_ff;

endmodule

FILE: sv/byte_protocol_sensor_register_slave_unit.sv
// a response is registered and shown in the cycle after its item is accepted
// throughput: one item per cycle while responses are taken; the phase controller
//   advances one step per item and the ring is one read or write at the cursor
// reset (synchronous, active high): phase idle, no response pending, device
//   address 0xE3, power mode 0, cursor 0, sample ring reloaded with its pattern
`timescale 1ns / 1ps

module byte_protocol_sensor_register_slave_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_status,
   output logic [7:0] rsp_read_data,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import bpsrs_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   bpsrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .stat       (stat),
      .cmd        (cmd)
   );

   bpsrs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data_byte    (req_data_byte),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data)
   );

endmodule

FILE: test/byte_protocol_sensor_register_slave_checker.sv
`timescale 1ns / 1ps

package bpsrs_tb_defs;

   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_READ  = 1'b1;

   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FAIL = 1'b1;

endpackage

module byte_protocol_sensor_register_slave_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_status,
   input  logic [7:0] rsp_read_data,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         replies_outstanding,
   output int         mismatch_count
);
   import bpsrs_pkg::*;
   import bpsrs_tb_defs::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_OPEN,
      PH_SELECT,
      PH_DATA,
      PH_END
   } bus_phase_type;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
   } reply_type;

   bus_phase_type     phase;
   logic              write_op;
   logic              ring_sel;
   logic [MODE_W-1:0] power_mode;
   logic [7:0]        samples [RING_DEPTH];
   int unsigned       cursor;
   logic [7:0]        dev_addr;
   reply_type         replies_due [$];
   int                mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic void reset_sensor();
      phase = PH_IDLE;
      write_op = 1'b0;
      ring_sel = 1'b0;
      power_mode = '0;
      cursor = 0;
      dev_addr = DEV_ADDR_RESET;
      for (int i = 0; i < RING_DEPTH; i++) begin
         samples[i] = (i < RING_INIT_LEN) ? RING_INIT[i] : 8'h00;
      end
   endfunction

   function automatic void bump_cursor();
      if (cursor + 1 >= RING_DEPTH) begin
         cursor = 0;
      end else begin
         cursor++;
      end
   endfunction

   // one bus byte through the protocol state, returns the reply it causes
   function automatic reply_type step_bus_byte(input logic op, input logic [7:0] b);
      reply_type r;
      r.status = ST_OK;
      r.read_data = 8'h00;
      if (op == OPC_WRITE) begin
         case (phase)
            PH_IDLE: begin
               if (b == dev_addr) phase = PH_OPEN;
               else r.status = ST_FAIL;
            end
            PH_OPEN: begin
               if (b == dev_addr) begin
                  phase = PH_IDLE;
               end else if (b == OP_READ_CODE || b == OP_WRITE_CODE) begin
                  write_op = (b == OP_WRITE_CODE);
                  phase = PH_SELECT;
               end else begin
                  r.status = ST_FAIL;
               end
            end
            PH_SELECT: begin
               if (b == dev_addr) begin
                  phase = PH_IDLE;
               end else if (b == REG_MODE_CODE || b == REG_RING_CODE) begin
                  ring_sel = (b == REG_RING_CODE);
                  phase = PH_DATA;
               end else begin
                  r.status = ST_FAIL;
               end
            end
            PH_DATA: begin
               phase = PH_END;
               if (!write_op) begin
                  r.status = ST_FAIL;
               end else if (ring_sel) begin
                  samples[cursor] = b;
                  bump_cursor();
               end else if (b < NUM_MODES) begin
                  power_mode = b[MODE_W-1:0];
               end else begin
                  r.status = ST_FAIL;
               end
            end
            PH_END: begin
               if (b == dev_addr) phase = PH_IDLE;
               else r.status = ST_FAIL;
            end
            default: begin
               phase = PH_IDLE;
               r.status = ST_FAIL;
            end
         endcase
      end else if (phase == PH_DATA) begin
         phase = PH_END;
         if (write_op) begin
            r.status = ST_FAIL;
         end else if (ring_sel) begin
            r.read_data = samples[cursor];
            bump_cursor();
         end else begin
            r.read_data = 8'(power_mode);
         end
      end else begin
         phase = PH_IDLE;
         r.status = ST_FAIL;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         reset_sensor();
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               report($sformatf("reply status %0d data %02h with no item waiting",
                                rsp_status, rsp_read_data));
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status) begin
                  report($sformatf("status %0d, wanted %0d", rsp_status, want.status));
               end
               if (rsp_read_data !== want.read_data) begin
                  report($sformatf("read data %02h, wanted %02h",
                                   rsp_read_data, want.read_data));
               end
            end
         end
         if (csr_write_enable) begin
            dev_addr = csr_write_data;
         end
         if (req_valid && req_ready) begin
            replies_due.push_back(step_bus_byte(req_opcode, req_data_byte));
         end
      end
      replies_outstanding <= replies_due.size();
   end

endmodule

FILE: test/tb_byte_protocol_sensor_register_slave_unit.sv
`timescale 1ns / 1ps

module tb_byte_protocol_sensor_register_slave_unit;
   import bpsrs_pkg::*;
   import bpsrs_tb_defs::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int ITEMS_PER_RUN = 215;
   localparam int NUM_RUNS      = 6;

   localparam logic [7:0] RUN_ADDR [NUM_RUNS] = '{8'h00, 8'hFF, 8'h21, 8'hE3, 8'hB3, 8'h5A};
   localparam int RUN_SEND_IDLE [NUM_RUNS]    = '{74, 0, 23, 0, 74, 0};
   localparam int RUN_RECV_STALL [NUM_RUNS]   = '{0, 74, 23, 0, 0, 74};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_opcode = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_status;
   logic [7:0] rsp_read_data;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   int         replies_outstanding;
   int         mismatch_count;
   int         quiet_cycles = 0;
   int         items_sent = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic [7:0] dev_addr = DEV_ADDR_RESET;

   always #10 clock = ~clock;

   byte_protocol_sensor_register_slave_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   byte_protocol_sensor_register_slave_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_read_data       (rsp_read_data),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .replies_outstanding (replies_outstanding),
      .mismatch_count      (mismatch_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_item(input logic op, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] addr);
      csr_write_enable <= 1'b1;
      csr_write_data <= addr;
      dev_addr = addr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // biased toward the bytes the protocol reacts to
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      case ($urandom_range(7))
         0: b = dev_addr;
         1: b = $urandom_range(1) ? OP_READ_CODE : OP_WRITE_CODE;
         2: b = $urandom_range(1) ? REG_MODE_CODE : REG_RING_CODE;
         3: b = 8'($urandom_range(NUM_MODES));
         default: b = 8'($urandom);
      endcase
      return b;
   endfunction

   task automatic bus_transaction();
      int   kind;
      int   depth;
      logic wr_op;
      logic ring_sel;
      kind = $urandom_range(99);
      wr_op = 1'($urandom_range(1));
      ring_sel = 1'($urandom_range(1));
      if (kind < 70) begin
         send_item(OPC_WRITE, dev_addr);
         send_item(OPC_WRITE, wr_op ? OP_WRITE_CODE : OP_READ_CODE);
         send_item(OPC_WRITE, ring_sel ? REG_RING_CODE : REG_MODE_CODE);
         if ($urandom_range(9) == 0) begin
            send_item(wr_op ? OPC_READ : OPC_WRITE, 8'($urandom));
         end else if (!wr_op) begin
            send_item(OPC_READ, 8'($urandom));
         end else if (ring_sel || $urandom_range(4) == 0) begin
            send_item(OPC_WRITE, 8'($urandom));
         end else begin
            send_item(OPC_WRITE, 8'($urandom_range(NUM_MODES - 1)));
         end
         send_item(OPC_WRITE, dev_addr);
      end else if (kind < 88) begin
         // cut short, then a read, which falls back to idle unless the phase is data
         depth = $urandom_range(3);
         if (depth > 0) send_item(OPC_WRITE, dev_addr);
         if (depth > 1) send_item(OPC_WRITE, wr_op ? OP_WRITE_CODE : OP_READ_CODE);
         if (depth > 2) send_item(OPC_WRITE, ring_sel ? REG_RING_CODE : REG_MODE_CODE);
         case ($urandom_range(2))
            0: send_item(OPC_WRITE, dev_addr);
            1: send_item(OPC_WRITE, pick_byte());
            default: send_item(OPC_READ, pick_byte());
         endcase
         send_item(OPC_READ, 8'($urandom));
      end else begin
         repeat ($urandom_range(3, 1)) send_item(1'($urandom_range(1)), pick_byte());
      end
   endtask

   task automatic random_run();
      int start;
      start = items_sent;
      while (items_sent - start < ITEMS_PER_RUN) bus_transaction();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // idle errors, open bad byte and abort, select abort
      send_item(OPC_READ, 8'h00);
      send_item(OPC_WRITE, 8'h00);
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, 8'h55);
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, OP_READ_CODE);
      send_item(OPC_WRITE, dev_addr);
      // select bad byte, mode out of range, end bad byte
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, OP_WRITE_CODE);
      send_item(OPC_WRITE, 8'h12);
      send_item(OPC_WRITE, REG_MODE_CODE);
      send_item(OPC_WRITE, 8'(NUM_MODES));
      send_item(OPC_WRITE, 8'hFF);
      send_item(OPC_WRITE, dev_addr);
      // top mode written and read back
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, OP_WRITE_CODE);
      send_item(OPC_WRITE, REG_MODE_CODE);
      send_item(OPC_WRITE, 8'(NUM_MODES - 1));
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, OP_READ_CODE);
      send_item(OPC_WRITE, REG_MODE_CODE);
      send_item(OPC_READ, 8'hFF);
      send_item(OPC_WRITE, dev_addr);
      // byte written during a read, then read in end
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, OP_READ_CODE);
      send_item(OPC_WRITE, REG_RING_CODE);
      send_item(OPC_WRITE, 8'h00);
      send_item(OPC_READ, 8'h00);
      // read during a write
      send_item(OPC_WRITE, dev_addr);
      send_item(OPC_WRITE, OP_WRITE_CODE);
      send_item(OPC_WRITE, REG_RING_CODE);
      send_item(OPC_READ, 8'h00);
      send_item(OPC_WRITE, dev_addr);

      random_run();
      for (int run = 0; run < NUM_RUNS; run++) begin
         drain();
         write_address(RUN_ADDR[run]);
         send_idle_pct = RUN_SEND_IDLE[run];
         recv_stall_pct = RUN_RECV_STALL[run];
         random_run();
      end
      drain();

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/bpsrs_pkg.sv
sv/bpsrs_ctrl.sv
sv/bpsrs_datapath.sv
sv/byte_protocol_sensor_register_slave_unit.sv
test/byte_protocol_sensor_register_slave_checker.sv
test/tb_byte_protocol_sensor_register_slave_unit.sv
